/* sv/tlvd_pkg.sv */
// Package for the TLV deframer: operation and result-kind codes, the result record.
// Used by tlvd_parser, tlvd_out_buf, tlv_deframer_with_flow_control and the testbench. No dependencies.
package tlvd_pkg;

	// default handler count; channels at or above it route to handler 0
	localparam int HANDLER_COUNT_DEF = 8;

	// input operation codes (carried on s_tuser)
	localparam logic OP_RX   = 1'b0;
	localparam logic OP_SEND = 1'b1;

	// result kind codes (carried on m_tuser)
	localparam logic [1:0] KIND_PAYLOAD = 2'd0;
	localparam logic [1:0] KIND_EMPTY   = 2'd1;
	localparam logic [1:0] KIND_SEND    = 2'd2;

	// one result item
	typedef struct packed {
		logic [1:0] kind;
		logic [2:0] handler;
		logic [7:0] frame_channel;
		logic [7:0] payload_byte;
		logic [7:0] byte_index;
		logic       last;
		logic       send_accepted;
		logic       send_paused;
	} res_t;

	// result record with its valid flag, parser to output buffer
	typedef struct packed {
		logic valid;
		res_t res;
	} res_bus_t;

endpackage

/* sv/tlvd_parser.sv */
// Frame parser: channel/length/payload state, send-pause flag and enable mask register.
// Computes the result of each accepted transaction in the same cycle. Depends on tlvd_pkg.
module tlvd_parser #(
	parameter int HANDLER_COUNT = tlvd_pkg::HANDLER_COUNT_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [7:0]         cfg_wr_data,
	input  logic               in_fire,
	input  logic               in_op,
	input  logic [7:0]         in_byte,
	output tlvd_pkg::res_bus_t res_o
);

	localparam logic [1:0] PH_CHAN = 2'd0;
	localparam logic [1:0] PH_LEN  = 2'd1;
	localparam logic [1:0] PH_DATA = 2'd2;
	localparam logic [7:0] HC8     = 8'(HANDLER_COUNT);

	logic [1:0] phase_q, phase_n;
	logic [7:0] ch_q, ch_n;
	logic [7:0] len_q, len_n;
	logic [7:0] seen_q, seen_n;
	logic       fbz_q, fbz_n;
	logic       pause_q, pause_n;
	logic [7:0] mask_q;

	logic [7:0] route_ch;
	logic       route_en;
	logic       is_last;
	logic       fbz_eff;
	tlvd_pkg::res_bus_t res;

	// route of the current frame and whether its handler is enabled
	assign route_ch = (ch_q < HC8) ? ch_q : 8'd0;
	assign route_en = (route_ch < 8'd8) && mask_q[route_ch[2:0]];

	assign is_last = ({1'b0, seen_q} + 9'd1) >= {1'b0, len_q};
	assign fbz_eff = (seen_q == 8'd0) ? (in_byte == 8'd0) : fbz_q;

	// next state and result for one transaction
	always_comb begin
		phase_n = phase_q;
		ch_n    = ch_q;
		len_n   = len_q;
		seen_n  = seen_q;
		fbz_n   = fbz_q;
		pause_n = pause_q;
		res     = '0;
		if (in_op == tlvd_pkg::OP_SEND) begin
			pause_n                 = 1'b1;
			res.valid               = 1'b1;
			res.res.kind            = tlvd_pkg::KIND_SEND;
			res.res.send_accepted   = !pause_q;
		end else begin
			case (phase_q)
				PH_LEN: begin
					len_n   = in_byte;
					seen_n  = 8'd0;
					fbz_n   = 1'b0;
					phase_n = (in_byte != 8'd0) ? PH_DATA : PH_CHAN;
					if (in_byte == 8'd0 && ch_q != 8'd0 && route_en) begin
						res.valid             = 1'b1;
						res.res.kind          = tlvd_pkg::KIND_EMPTY;
						res.res.handler       = route_ch[2:0];
						res.res.frame_channel = ch_q;
						res.res.last          = 1'b1;
					end
				end
				PH_DATA: begin
					fbz_n  = fbz_eff;
					seen_n = seen_q + 8'd1;
					if (is_last)
						phase_n = PH_CHAN;
					if (ch_q == 8'd0) begin
						// flow-control frame: zero tag then pause value
						if (is_last && len_q == 8'd2 && fbz_eff)
							pause_n = (in_byte != 8'd0);
					end else if (route_en) begin
						res.valid             = 1'b1;
						res.res.kind          = tlvd_pkg::KIND_PAYLOAD;
						res.res.handler       = route_ch[2:0];
						res.res.frame_channel = ch_q;
						res.res.payload_byte  = in_byte;
						res.res.byte_index    = seen_q;
						res.res.last          = is_last;
					end
				end
				default: begin
					ch_n    = in_byte;
					phase_n = PH_LEN;
				end
			endcase
		end
		res.res.send_paused = pause_n;
		res.valid           = res.valid && in_fire;
	end

	assign res_o = res;

	// parse state, updated on each accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_CHAN;
			ch_q    <= 8'd0;
			len_q   <= 8'd0;
			seen_q  <= 8'd0;
			fbz_q   <= 1'b0;
			pause_q <= 1'b0;
		end else if (in_fire) begin
			phase_q <= phase_n;
			ch_q    <= ch_n;
			len_q   <= len_n;
			seen_q  <= seen_n;
			fbz_q   <= fbz_n;
			pause_q <= pause_n;
		end
	end

	// handler enable mask
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			mask_q <= 8'd0;
		else if (cfg_wr_en)
			mask_q <= cfg_wr_data;
	end

	// a send request always answers and leaves the block paused
	a_send_answers: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && in_op == tlvd_pkg::OP_SEND |-> res_o.valid)
		else $error("send request without answer");
	a_send_pauses: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && in_op == tlvd_pkg::OP_SEND |=> pause_q)
		else $error("pause not set after send request");
	a_data_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DATA |-> seen_q < len_q)
		else $error("byte count ran past frame length");

endmodule

/* sv/tlvd_out_buf.sv */
// Output register with a skid stage: holds results while the master side stalls.
// Depends on tlvd_pkg.
module tlvd_out_buf (
	input  logic               clk,
	input  logic               arst_n,
	input  tlvd_pkg::res_bus_t res_i,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	output tlvd_pkg::res_t     out_res
);

	logic           main_v_q, skid_v_q;
	tlvd_pkg::res_t main_q, skid_q;
	logic           out_fire;

	assign in_ready  = !skid_v_q;
	assign out_valid = main_v_q;
	assign out_res   = main_q;
	assign out_fire  = main_v_q && out_ready;

	// valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!main_v_q || out_fire) begin
			main_v_q <= skid_v_q || res_i.valid;
			skid_v_q <= 1'b0;
		end else if (res_i.valid) begin
			skid_v_q <= 1'b1;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (!main_v_q || out_fire)
			main_q <= skid_v_q ? skid_q : res_i.res;
		else if (res_i.valid)
			skid_q <= res_i.res;
	end

	a_skid_implies_main: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> main_v_q)
		else $error("skid stage full while output register empty");
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q && !out_fire |=> skid_v_q && $stable(skid_q))
		else $error("skid stage overwritten");
	a_result_lands: assert property (@(posedge clk) disable iff (!arst_n)
		res_i.valid && !main_v_q |=> main_v_q)
		else $error("result lost on empty buffer");

endmodule

/* sv/tlv_deframer_with_flow_control.sv */
// TLV deframer with send flow control, top level.
// Results are registered in the output buffer before they reach the master side.
// Throughput: one input transaction per cycle; the skid stage keeps s_tready high
// for one stalled result, after which s_tready drops until m_tready drains it.
// Reset (arst_n, asynchronous): parser at channel byte, not paused, enable mask 0.
// Depends on tlvd_pkg, tlvd_parser, tlvd_out_buf.
module tlv_deframer_with_flow_control #(
	parameter int HANDLER_COUNT = tlvd_pkg::HANDLER_COUNT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration: handler_enable_mask
	input  logic        cfg_wr_en,
	input  logic [7:0]  cfg_wr_data,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	input  logic        s_tuser,   // [0] operation
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [2:0] handler, [10:3] frame_channel, [18:11] payload_byte,
	                               // [26:19] byte_index, [27] send_accepted,
	                               // [28] send_paused, [31:29] zero
	output logic [1:0]  m_tuser,   // [1:0] kind
	output logic        m_tlast    // last
);

	tlvd_pkg::res_bus_t res_bus;
	tlvd_pkg::res_t     out_res;
	logic               in_fire;

	assign in_fire = s_tvalid && s_tready;

	tlvd_parser #(
		.HANDLER_COUNT(HANDLER_COUNT)
	) u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_fire    (in_fire),
		.in_op      (s_tuser),
		.in_byte    (s_tdata),
		.res_o      (res_bus)
	);

	tlvd_out_buf u_out_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.res_i    (res_bus),
		.in_ready (s_tready),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_res  (out_res)
	);

	// pack the result transaction
	assign m_tdata = {3'b000, out_res.send_paused, out_res.send_accepted, out_res.byte_index,
		out_res.payload_byte, out_res.frame_channel, out_res.handler};
	assign m_tuser = out_res.kind;
	assign m_tlast = out_res.last;

endmodule

/* tb/sv/tlvd_checker.sv */
`timescale 1ns / 100ps
// Checker for the TLV deframer: watches the config, input and result channels,
// predicts each result and compares it field by field. Depends on tlvd_pkg.
module tlvd_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [7:0]  cfg_wr_data,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	input  logic        s_tuser,   // [0] operation
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,   // [2:0] handler, [10:3] frame_channel, [18:11] payload_byte,
	                               // [26:19] byte_index, [27] send_accepted,
	                               // [28] send_paused, [31:29] zero
	input  logic [1:0]  m_tuser,   // [1:0] kind
	input  logic        m_tlast,
	output int          fail_count,
	output int          results_pending,
	output int          results_checked
);

	typedef enum logic [1:0] {
		PH_CHANNEL = 2'd0,
		PH_LENGTH  = 2'd1,
		PH_DATA    = 2'd2
	} parse_phase_t;

	// predictor state, a private copy of the block's
	logic [7:0]   enable_mask;
	parse_phase_t phase;
	logic [7:0]   cur_channel;
	logic [7:0]   cur_length;
	logic [7:0]   bytes_seen;
	logic         first_zero;
	logic         paused;

	tlvd_pkg::res_t expected_results[$];

	// channels at or above the handler count fall back to handler 0
	function automatic int route_handler(input logic [7:0] ch);
		return (int'(ch) < tlvd_pkg::HANDLER_COUNT_DEF) ? int'(ch) : 0;
	endfunction

	function automatic bit handler_enabled(input int h);
		if (h >= 8)
			return 1'b0;
		return enable_mask[h];
	endfunction

	// advance the deframer by one input transaction; 1 when a result follows
	function automatic bit deframe_step(input logic op, input logic [7:0] b,
		output tlvd_pkg::res_t r);
		logic [7:0] idx;
		bit         is_last;
		int         h;
		r = '0;
		if (op == tlvd_pkg::OP_SEND) begin
			r.kind          = tlvd_pkg::KIND_SEND;
			r.send_accepted = !paused;
			paused          = 1'b1;
			r.send_paused   = 1'b1;
			return 1'b1;
		end
		h = route_handler(cur_channel);
		case (phase)
			PH_LENGTH: begin
				cur_length = b;
				bytes_seen = 8'd0;
				first_zero = 1'b0;
				if (b != 8'd0) begin
					phase = PH_DATA;
					return 1'b0;
				end
				// empty frame: one notice, unless flow-control channel or disabled
				phase = PH_CHANNEL;
				if (cur_channel == 8'd0 || !handler_enabled(h))
					return 1'b0;
				r.kind          = tlvd_pkg::KIND_EMPTY;
				r.handler       = 3'(h);
				r.frame_channel = cur_channel;
				r.last          = 1'b1;
				r.send_paused   = paused;
				return 1'b1;
			end
			PH_DATA: begin
				idx     = bytes_seen;
				is_last = ({1'b0, idx} + 9'd1) >= {1'b0, cur_length};
				if (idx == 8'd0)
					first_zero = (b == 8'd0);
				bytes_seen = idx + 8'd1;
				if (is_last)
					phase = PH_CHANNEL;
				// channel 0: only "00 xx" of length 2 touches the pause flag
				if (cur_channel == 8'd0) begin
					if (is_last && cur_length == 8'd2 && first_zero)
						paused = (b != 8'd0);
					return 1'b0;
				end
				if (!handler_enabled(h))
					return 1'b0;
				r.kind          = tlvd_pkg::KIND_PAYLOAD;
				r.handler       = 3'(h);
				r.frame_channel = cur_channel;
				r.payload_byte  = b;
				r.byte_index    = idx;
				r.last          = is_last;
				r.send_paused   = paused;
				return 1'b1;
			end
			default: begin
				cur_channel = b;
				phase       = PH_LENGTH;
				return 1'b0;
			end
		endcase
	endfunction

	task automatic report(input string field, input logic [31:0] exp_v, input logic [31:0] act_v);
		$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, exp_v, act_v);
		fail_count++;
	endtask

	// result check first, then prediction of this edge's input transaction
	always @(posedge clk or negedge arst_n) begin : monitor
		tlvd_pkg::res_t exp_r;
		tlvd_pkg::res_t new_r;
		if (!arst_n) begin
			enable_mask     = 8'd0;
			phase           = PH_CHANNEL;
			cur_channel     = 8'd0;
			cur_length      = 8'd0;
			bytes_seen      = 8'd0;
			first_zero      = 1'b0;
			paused          = 1'b0;
			fail_count      = 0;
			results_checked = 0;
			expected_results.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result transaction, expected none, actual kind %0h tdata %h",
						$time, m_tuser, m_tdata);
					fail_count++;
				end else begin
					exp_r = expected_results.pop_front();
					if (m_tuser !== exp_r.kind)
						report("kind", 32'(exp_r.kind), 32'(m_tuser));
					if (m_tdata[2:0] !== exp_r.handler)
						report("handler", 32'(exp_r.handler), 32'(m_tdata[2:0]));
					if (m_tdata[10:3] !== exp_r.frame_channel)
						report("frame_channel", 32'(exp_r.frame_channel), 32'(m_tdata[10:3]));
					if (m_tdata[18:11] !== exp_r.payload_byte)
						report("payload_byte", 32'(exp_r.payload_byte), 32'(m_tdata[18:11]));
					if (m_tdata[26:19] !== exp_r.byte_index)
						report("byte_index", 32'(exp_r.byte_index), 32'(m_tdata[26:19]));
					if (m_tlast !== exp_r.last)
						report("last", 32'(exp_r.last), 32'(m_tlast));
					if (m_tdata[27] !== exp_r.send_accepted)
						report("send_accepted", 32'(exp_r.send_accepted), 32'(m_tdata[27]));
					if (m_tdata[28] !== exp_r.send_paused)
						report("send_paused", 32'(exp_r.send_paused), 32'(m_tdata[28]));
					if (m_tdata[31:29] !== 3'd0)
						report("tdata padding", 32'd0, 32'(m_tdata[31:29]));
					results_checked++;
				end
			end
			if (s_tvalid && s_tready) begin
				if (deframe_step(s_tuser, s_tdata, new_r))
					expected_results.push_back(new_r);
			end
			if (cfg_wr_en)
				enable_mask = cfg_wr_data;
		end
		results_pending = expected_results.size();
	end

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps
// Top of the TLV deframer testbench: clock, reset, stimulus, output stalls and verdict.
// Depends on tlvd_pkg, tlv_deframer_with_flow_control and tlvd_checker.
module tb_top;

	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        cfg_wr_en   = 1'b0;
	logic [7:0]  cfg_wr_data = 8'd0;
	logic        s_tvalid    = 1'b0;
	logic [7:0]  s_tdata     = 8'd0;   // [7:0] rx_byte
	logic        s_tuser     = 1'b0;   // [0] operation
	logic        m_tready    = 1'b0;
	wire         s_tready;
	wire         m_tvalid;
	wire  [31:0] m_tdata;              // [2:0] handler, [10:3] frame_channel, [18:11] payload_byte,
	                                   // [26:19] byte_index, [27] send_accepted,
	                                   // [28] send_paused, [31:29] zero
	wire  [1:0]  m_tuser;              // [1:0] kind
	wire         m_tlast;

	int   fail_count;
	int   results_pending;
	int   results_checked;
	int   send_gap_pct   = 0;
	int   recv_stall_pct = 0;
	int   items_sent     = 0;
	int   masks_used     = 0;
	logic in_accepted    = 1'b0;
	logic hold_active    = 1'b0;
	event hold_start;

	always #5 clk = ~clk;

	tlv_deframer_with_flow_control #(
		.HANDLER_COUNT(tlvd_pkg::HANDLER_COUNT_DEF)
	) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast)
	);

	tlvd_checker u_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.s_tuser        (s_tuser),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.m_tuser        (m_tuser),
		.m_tlast        (m_tlast),
		.fail_count     (fail_count),
		.results_pending(results_pending),
		.results_checked(results_checked)
	);

	// input transaction seen at the edge, read back by the driver at the next falling edge
	always @(posedge clk)
		in_accepted <= s_tvalid && s_tready;

	// long output hold-off, counted here so the sender keeps going
	initial begin
		forever begin
			@(hold_start);
			hold_active = 1'b1;
			repeat (300) @(negedge clk);
			hold_active = 1'b0;
		end
	end

	// receiver: random stalls plus the hold-off
	always @(negedge clk)
		m_tready <= !hold_active && ($urandom_range(99) >= recv_stall_pct);

	// one input transaction, with random idle cycles in front
	task automatic push_item(input logic op, input logic [7:0] b);
		while ($urandom_range(99) < send_gap_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= b;
		@(negedge clk);
		while (!in_accepted)
			@(negedge clk);
		items_sent++;
	endtask

	// mask write only once the block has drained
	task automatic write_mask(input logic [7:0] m);
		s_tvalid <= 1'b0;
		while (results_pending != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= m;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		masks_used++;
	endtask

	// a send request, a bit of noise, or a whole frame with random content
	task automatic random_chunk();
		int         pick;
		logic [7:0] ch;
		int         len;
		logic [7:0] b;
		pick = $urandom_range(99);
		if (pick < 10) begin
			push_item(tlvd_pkg::OP_SEND, 8'($urandom_range(255)));
		end else if (pick < 20) begin
			push_item(1'($urandom_range(1)), 8'($urandom_range(255)));
		end else begin
			pick = $urandom_range(99);
			if (pick < 50)
				ch = 8'($urandom_range(7, 1));
			else if (pick < 75)
				ch = 8'($urandom_range(255, 8));
			else
				ch = 8'd0;
			pick = $urandom_range(99);
			if (ch == 8'd0 && pick < 70)
				len = 2;
			else if (pick < 10)
				len = 0;
			else if (pick < 45)
				len = $urandom_range(3, 1);
			else if (pick < 95)
				len = $urandom_range(12, 4);
			else if (pick < 99)
				len = $urandom_range(40, 13);
			else
				len = $urandom_range(255, 200);
			push_item(tlvd_pkg::OP_RX, ch);
			push_item(tlvd_pkg::OP_RX, 8'(len));
			for (int i = 0; i < len; i++) begin
				if ($urandom_range(99) < 5)
					push_item(tlvd_pkg::OP_SEND, 8'($urandom_range(255)));
				b = 8'($urandom_range(255));
				if (ch == 8'd0 && i == 0 && $urandom_range(99) < 75)
					b = 8'd0;
				push_item(tlvd_pkg::OP_RX, b);
			end
		end
	endtask

	initial begin : stimulus
		logic [7:0] m;
		int         phase_start;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: send answers, pause control, empty frames, high channel
		write_mask(8'hFF);
		push_item(tlvd_pkg::OP_SEND, 8'h00);      // accepted, pauses
		push_item(tlvd_pkg::OP_SEND, 8'hFF);      // refused while paused
		push_item(tlvd_pkg::OP_RX, 8'h00);        // channel 0, 00 00 clears pause
		push_item(tlvd_pkg::OP_RX, 8'h02);
		push_item(tlvd_pkg::OP_RX, 8'h00);
		push_item(tlvd_pkg::OP_RX, 8'h00);
		push_item(tlvd_pkg::OP_RX, 8'h05);        // empty frame on an enabled handler
		push_item(tlvd_pkg::OP_RX, 8'h00);
		push_item(tlvd_pkg::OP_RX, 8'h00);        // empty frame on channel 0, dropped
		push_item(tlvd_pkg::OP_RX, 8'h00);
		push_item(tlvd_pkg::OP_RX, 8'hC8);        // high channel routes to handler 0
		push_item(tlvd_pkg::OP_RX, 8'h02);
		push_item(tlvd_pkg::OP_RX, 8'hFF);
		push_item(tlvd_pkg::OP_RX, 8'h00);
		push_item(tlvd_pkg::OP_RX, 8'h07);        // send request in the middle of a frame
		push_item(tlvd_pkg::OP_RX, 8'h01);
		push_item(tlvd_pkg::OP_SEND, 8'h5A);
		push_item(tlvd_pkg::OP_RX, 8'hAB);
		push_item(tlvd_pkg::OP_RX, 8'h00);        // channel 0, 00 01 sets pause
		push_item(tlvd_pkg::OP_RX, 8'h02);
		push_item(tlvd_pkg::OP_RX, 8'h00);
		push_item(tlvd_pkg::OP_RX, 8'h01);
		push_item(tlvd_pkg::OP_RX, 8'h00);        // channel 0 of length 1, dropped
		push_item(tlvd_pkg::OP_RX, 8'h01);
		push_item(tlvd_pkg::OP_RX, 8'h00);

		// random phases, each with a mask and one of four idle patterns
		for (int phase = 0; phase < 8; phase++) begin
			case (phase)
				0, 6:    m = 8'hFF;
				1:       m = 8'h00;
				3:       m = 8'h01;
				4:       m = 8'h80;
				default: m = 8'($urandom_range(255));
			endcase
			write_mask(m);
			case (phase % 4)
				0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_gap_pct = 57; recv_stall_pct = 0;  end
				2: begin send_gap_pct = 0;  recv_stall_pct = 57; end
				default: begin send_gap_pct = 14; recv_stall_pct = 14; end
			endcase
			if (phase == 0)
				-> hold_start;
			phase_start = items_sent;
			while (items_sent - phase_start < 150)
				random_chunk();
		end

		// drain, then a few quiet cycles
		s_tvalid <= 1'b0;
		while (results_pending != 0)
			@(negedge clk);
		repeat (5) @(negedge clk);

		$display("Run covered %0d input and %0d result transactions under %0d enable masks,",
			items_sent, results_checked, masks_used);
		$display("four idle patterns and one long output hold-off.");
		if (fail_count == 0 && results_pending == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// watchdog
	initial begin
		#2000000;
		$display("Some tests failed");
		$finish;
	end

endmodule

/* tlv_deframer_with_flow_control.f */
sv/tlvd_pkg.sv
sv/tlvd_parser.sv
sv/tlvd_out_buf.sv
sv/tlv_deframer_with_flow_control.sv
tb/sv/tlvd_checker.sv
tb/sv/tb_top.sv
